[hw/rtl/lbp_pkg.sv]
// Shared constants, config register codes and the LBP code function for lbp_3x3_feature.
// No dependencies; every other file in hw/rtl uses it.
package lbp_pkg;

    localparam int PIXEL_W      = 8;
    localparam int CODE_W       = 8;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int MAX_WIDTH_DEFAULT = 2048;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    // Config register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // Neighbors in code bit order: up, up-right, right, down-right,
    // down, down-left, left, up-left.
    typedef pixel_t [7:0] nbr_t;

    // One bit per neighbor, set when the neighbor is strictly brighter.
    function automatic logic [CODE_W-1:0] lbp_code(input pixel_t center, input nbr_t nbr);
        logic [CODE_W-1:0] c;
        c = '0;
        for (int k = 0; k < 8; k++)
        begin
            c[k] = (nbr[k] > center);
        end
        return c;
    endfunction

endpackage

[hw/rtl/lbp_if.sv]
// Valid/ready stream interfaces for the pixel and code channels.
// Depends on lbp_pkg for payload widths.
interface lbp_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [lbp_pkg::PIXEL_W-1:0] pixel;
    logic                        frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface lbp_code_if;
    logic                       valid;
    logic                       ready;
    logic [lbp_pkg::CODE_W-1:0] code;
    logic                       frame_end;

    modport source (output valid, output code, output frame_end, input ready);
    modport sink   (input valid, input code, input frame_end, output ready);
endinterface

[hw/rtl/lbp_line_mem.sv]
// Two line stores (previous row and the row before) with registered reads
// and write-to-read bypass. Depends on lbp_pkg.
module lbp_line_mem #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEFAULT,
    parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [ADDR_W-1:0]      rd_addr,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  lbp_pkg::pixel_t        wr_mid,   // new row r-1 entry (current pixel)
    input  lbp_pkg::pixel_t        wr_top,   // new row r-2 entry (old row r-1)
    output lbp_pkg::pixel_t        rd_top,
    output lbp_pkg::pixel_t        rd_mid
);

    lbp_pkg::pixel_t mem_a [MAX_WIDTH];   // row r-1
    lbp_pkg::pixel_t mem_b [MAX_WIDTH];   // row r-2
    lbp_pkg::pixel_t rd_top_reg;
    lbp_pkg::pixel_t rd_mid_reg;
    logic            bypass;

    assign bypass = wr_en && (wr_addr == rd_addr);

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_mid;
            mem_b[wr_addr] <= wr_top;
        end
    end

    // Read port, newest data wins on an address match
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_mid_reg <= bypass ? wr_mid : mem_a[rd_addr];
            rd_top_reg <= bypass ? wr_top : mem_b[rd_addr];
        end
    end

    assign rd_top = rd_top_reg;
    assign rd_mid = rd_mid_reg;

endmodule

[hw/rtl/lbp_3x3_feature.sv]
// Top level of the streaming 3x3 local binary pattern block.
// Depends on lbp_pkg, lbp_if.sv and lbp_line_mem.
//
// Takes one 8-bit pixel beat per clock in raster order while the output is not
// stalled, and returns one 8-bit LBP code beat for each interior pixel (border
// pixels give no beat; the consumer pads them). The code of center (r-1, c-1)
// leaves through the registered line-store read and stage 1 register, and the
// comparison into the output register. Throughput, when not stalled, is one
// pixel per clock, set by the single read and write port of each line store;
// pixel ready follows the output register's ready combinationally. The line
// stores are MAX_WIDTH x 8 memories with no clearing pass. frame_start resets
// the position; after the last pixel the position wraps by itself. Write
// image_width / image_height only while no beat is in flight; a change in
// mid-frame keeps the position, and a position beyond the new size gives no
// code and wraps at its next advance.
module lbp_3x3_feature #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lbp_pixel_if.sink                         pixels,
    lbp_code_if.source                        codes,
    input  logic                              cfg_we,
    input  lbp_pkg::cfg_index_t               cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int CW     = ((WEFF_W > lbp_pkg::CFG_WIDTH_W) ? WEFF_W
                                                             : lbp_pkg::CFG_WIDTH_W) + 1;
    localparam int RW     = lbp_pkg::CFG_HEIGHT_W;

    // Config registers
    logic [lbp_pkg::CFG_WIDTH_W-1:0]  width_reg;
    logic [lbp_pkg::CFG_HEIGHT_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lbp_pkg::WIDTH_RESET;
            height_reg <= lbp_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lbp_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[lbp_pkg::CFG_WIDTH_W-1:0];
                lbp_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data[lbp_pkg::CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, width clamps to MAX_WIDTH
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = CW'(1);
        else if (CW'(width_reg) > CW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_reg);
        h_eff = (height_reg == '0) ? RW'(1) : height_reg;
    end

    // Pipeline handshake
    logic s1_valid_reg, s1_valid_next;
    logic s1_emit_reg;
    logic s1_last_reg;
    logic [COL_W-1:0] s1_col_reg;
    lbp_pkg::pixel_t  s1_pixel_reg;
    logic out_valid_reg;
    logic s1_adv;
    logic accept;

    assign s1_adv = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || codes.ready);
    assign pixels.ready = !s1_valid_reg || s1_adv;
    assign accept = pixels.valid && pixels.ready;

    // Position of the arriving pixel and next position
    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [RW-1:0]    row_reg, row_next, row_cur;
    logic [CW-1:0]    col_ext;
    logic             emit_cur, last_cur;

    always_comb
    begin
        col_cur  = pixels.frame_start ? '0 : col_reg;
        row_cur  = pixels.frame_start ? '0 : row_reg;
        col_ext  = CW'(col_cur);
        emit_cur = (row_cur >= RW'(2)) && (col_ext >= CW'(2))
                   && (row_cur < h_eff) && (col_ext < w_eff);
        last_cur = (row_cur == h_eff - RW'(1)) && (col_ext == w_eff - CW'(1));
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_ext + CW'(1) >= w_eff)
            begin
                col_next = '0;
                row_next = ((RW+1)'(row_cur) + (RW+1)'(1) >= (RW+1)'(h_eff))
                           ? '0 : row_cur + RW'(1);
            end
            else
            begin
                col_next = col_cur + COL_W'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line stores: read on accept, write back when the beat leaves stage 1
    lbp_pkg::pixel_t top, mid;

    lbp_line_mem #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_mid  (s1_pixel_reg),
        .wr_top  (mid),
        .rd_top  (top),
        .rd_mid  (mid)
    );

    // Stage 1 register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                s1_emit_reg <= emit_cur;
                s1_last_reg <= last_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= col_cur;
            s1_pixel_reg <= pixels.pixel;
        end
    end

    // Window: columns c-1 (0..2) and c-2 (3..5), top/mid/bottom
    lbp_pkg::pixel_t win_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_adv)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top;
            win_reg[1] <= mid;
            win_reg[2] <= s1_pixel_reg;
        end
    end

    // Comparison
    lbp_pkg::nbr_t             nbr;
    logic [lbp_pkg::CODE_W-1:0] code_next;

    always_comb
    begin
        nbr[0] = win_reg[0];
        nbr[1] = top;
        nbr[2] = mid;
        nbr[3] = s1_pixel_reg;
        nbr[4] = win_reg[2];
        nbr[5] = win_reg[5];
        nbr[6] = win_reg[4];
        nbr[7] = win_reg[3];
        code_next = lbp_pkg::lbp_code(win_reg[1], nbr);
    end

    // Output register
    logic [lbp_pkg::CODE_W-1:0] code_reg;
    logic                       frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_emit_reg)
            out_valid_reg <= 1'b1;
        else if (codes.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            code_reg      <= code_next;
            frame_end_reg <= s1_last_reg;
        end
    end

    assign codes.valid     = out_valid_reg;
    assign codes.code      = code_reg;
    assign codes.frame_end = frame_end_reg;

`ifndef NO_ASSERTIONS
    // An accepted pixel beat always lands in stage 1
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel beat did not reach stage 1");

    // The window only moves when a beat leaves stage 1
    a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> ($stable(win_reg[0]) && $stable(win_reg[1]) && $stable(win_reg[2])))
        else $error("window changed without a stage 1 advance");

    // A new code beat comes only from an interior pixel leaving stage 1
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv && s1_emit_reg))
        else $error("code beat without an interior pixel");

    // A waiting code is never overwritten by a stalled pipeline
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !codes.ready) |-> !(s1_adv && s1_emit_reg))
        else $error("pending code beat overwritten");
`endif

endmodule

[tb/sv/lbp_3x3_feature_tb.sv]
// Self-checking testbench for lbp_3x3_feature: streams pixel frames of many sizes through
// the block, predicts every LBP code beat in a small scoreboard class and compares each one.
// Depends on lbp_pkg, the lbp_pixel_if / lbp_code_if interfaces and the lbp_3x3_feature RTL.
`timescale 1ns / 100ps

module lbp_3x3_feature_tb;

    localparam int LINE_DEPTH   = lbp_pkg::MAX_WIDTH_DEFAULT;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;      // margin for the block's stage 1 and output registers to drain
    localparam int HOLD_CYCLES  = 400;
    localparam int PRESS_W      = 32;     // row width of the hold-off frame
    localparam int RANDOM_ITEMS = 100;

    typedef struct packed {
        logic [lbp_pkg::CODE_W-1:0] code;
        logic                       frame_end;
    } code_beat_t;

    // Predicts code beats from accepted pixel beats and checks the block's output against them
    class lbp_scoreboard;
        logic [lbp_pkg::CFG_WIDTH_W-1:0]  width_reg;
        logic [lbp_pkg::CFG_HEIGHT_W-1:0] height_reg;
        lbp_pkg::pixel_t         row_prev  [LINE_DEPTH];   // row r-1
        lbp_pkg::pixel_t         row_prev2 [LINE_DEPTH];   // row r-2
        lbp_pkg::pixel_t         window    [6];            // col c-1 at 0..2, col c-2 at 3..5
        int unsigned             col;
        int unsigned             row;
        code_beat_t              expected_codes [$];
        int unsigned             pixels_seen;
        int unsigned             codes_checked;
        int unsigned             frames_done;
        int unsigned             mismatches;

        function new();
            width_reg  = lbp_pkg::WIDTH_RESET;
            height_reg = lbp_pkg::HEIGHT_RESET;
            foreach (row_prev[i])
            begin
                row_prev[i]  = '0;
                row_prev2[i] = '0;
            end
            foreach (window[i])
            begin
                window[i] = '0;
            end
            col           = 0;
            row           = 0;
            pixels_seen   = 0;
            codes_checked = 0;
            frames_done   = 0;
            mismatches    = 0;
        endfunction

        function void set_reg(input lbp_pkg::cfg_index_t idx,
                              input logic [lbp_pkg::CFG_DATA_W-1:0] data);
            if (idx == lbp_pkg::CFG_IMAGE_WIDTH)
            begin
                width_reg = data[lbp_pkg::CFG_WIDTH_W-1:0];
            end
            else
            begin
                height_reg = data[lbp_pkg::CFG_HEIGHT_W-1:0];
            end
        endfunction

        function void note_pixel(input lbp_pkg::pixel_t px, input logic frame_start);
            int unsigned                w;
            int unsigned                h;
            int unsigned                idx;
            lbp_pkg::pixel_t            up_px;
            lbp_pkg::pixel_t            mid_px;
            lbp_pkg::pixel_t            cen;
            logic [lbp_pkg::CODE_W-1:0] c;
            code_beat_t                 beat;

            pixels_seen++;
            // zero width or height acts as one, width clamps at the line store depth
            w = width_reg;
            if (w == 0)
            begin
                w = 1;
            end
            if (w > LINE_DEPTH)
            begin
                w = LINE_DEPTH;
            end
            h = height_reg;
            if (h == 0)
            begin
                h = 1;
            end

            if (frame_start)
            begin
                col = 0;
                row = 0;
            end
            idx    = (col < LINE_DEPTH) ? col : LINE_DEPTH - 1;
            up_px  = row_prev2[idx];
            mid_px = row_prev[idx];

            // interior center (row-1, col-1) completes with this pixel
            if (row >= 2 && col >= 2 && row < h && col < w)
            begin
                cen  = window[1];
                c[0] = window[0] > cen;   // up
                c[1] = up_px > cen;       // up-right
                c[2] = mid_px > cen;      // right
                c[3] = px > cen;          // down-right
                c[4] = window[2] > cen;   // down
                c[5] = window[5] > cen;   // down-left
                c[6] = window[4] > cen;   // left
                c[7] = window[3] > cen;   // up-left
                beat.code      = c;
                beat.frame_end = (row == h - 1) && (col == w - 1);
                expected_codes.push_back(beat);
            end

            window[3] = window[0];
            window[4] = window[1];
            window[5] = window[2];
            window[0] = up_px;
            window[1] = mid_px;
            window[2] = px;
            row_prev2[idx] = mid_px;
            row_prev[idx]  = px;

            // raster advance, wrapping into the next frame on its own
            if (col + 1 >= w)
            begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end
            else
            begin
                col++;
            end
        endfunction

        function void check_code(input logic [lbp_pkg::CODE_W-1:0] code, input logic frame_end);
            code_beat_t want;

            if (expected_codes.size() == 0)
            begin
                mismatches++;
                $error("unexpected code beat: code %02h frame_end %0b", code, frame_end);
                return;
            end
            want = expected_codes.pop_front();
            codes_checked++;
            if (want.frame_end)
            begin
                frames_done++;
            end
            if (code !== want.code)
            begin
                mismatches++;
                $error("code: expected %02h, got %02h", want.code, code);
            end
            if (frame_end !== want.frame_end)
            begin
                mismatches++;
                $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    lbp_pkg::cfg_index_t            cfg_index;
    logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data;

    lbp_pixel_if pix_if ();
    lbp_code_if  code_if ();

    lbp_3x3_feature dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_if),
        .codes     (code_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lbp_scoreboard sb;
    int unsigned   gap_pct = 0;       // chance of a sender gap before a beat
    int unsigned   stall_pct = 0;     // chance of a receiver stall per cycle
    bit            hold_off_req = 1'b0;
    int unsigned   cycle_count = 0;
    int unsigned   cfg_writes = 0;

    // every neighbor brighter than a black center: all bits set
    lbp_pkg::pixel_t grid_hot [9] = '{8'd255, 8'd255, 8'd255,
                                      8'd255, 8'd0,   8'd255,
                                      8'd255, 8'd255, 8'd255};
    // up, right, down, left one above center, diagonals equal: alternating bits
    lbp_pkg::pixel_t grid_alt [9] = '{8'd128, 8'd129, 8'd128,
                                      8'd129, 8'd128, 8'd129,
                                      8'd128, 8'd129, 8'd128};

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Beat monitor for both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_if.valid && pix_if.ready)
            begin
                sb.note_pixel(pix_if.pixel, pix_if.frame_start);
            end
            if (code_if.valid && code_if.ready)
            begin
                sb.check_code(code_if.code, code_if.frame_end);
            end
        end
    end

    // Code receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        code_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                code_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                code_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            code_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    function automatic lbp_pkg::pixel_t pick_pixel(input int unsigned mode,
                                                   input lbp_pkg::pixel_t base);
        case (mode)
            2:       return lbp_pkg::pixel_t'(base + lbp_pkg::pixel_t'($urandom_range(0, 2)));
            3:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return lbp_pkg::pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    // One pixel beat; returns at the edge where it was accepted, valid left high
    task automatic send_pixel(input lbp_pkg::pixel_t px, input logic frame_start);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel       <= px;
        pix_if.frame_start <= frame_start;
        @(posedge clk);
        while (!pix_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    // A run of pixels with one content style; noisy runs get rare stray frame starts
    task automatic send_run(input int unsigned count, input logic start_first, input bit noisy);
        int unsigned     mode;
        lbp_pkg::pixel_t base;
        logic            fs;

        mode = $urandom_range(0, 3);
        base = lbp_pkg::pixel_t'($urandom_range(0, 255));
        for (int unsigned i = 0; i < count; i++)
        begin
            fs = (i == 0) ? start_first : (noisy && $urandom_range(0, 199) == 0);
            send_pixel(pick_pixel(mode, base), fs);
        end
    endtask

    task automatic send_grid(input lbp_pkg::pixel_t grid [9], input logic start_first);
        for (int i = 0; i < 9; i++)
        begin
            send_pixel(grid[i], (i == 0) ? start_first : 1'b0);
        end
    endtask

    // Stop sending, let every expected code drain, then let the pipeline settle
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write
    task automatic cfg_write(input lbp_pkg::cfg_index_t idx,
                             input logic [lbp_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic set_size(input logic [lbp_pkg::CFG_DATA_W-1:0] w,
                            input logic [lbp_pkg::CFG_DATA_W-1:0] h);
        wait_idle();
        cfg_write(lbp_pkg::CFG_IMAGE_WIDTH, w);
        cfg_write(lbp_pkg::CFG_IMAGE_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        int unsigned cut;
        int unsigned random_sent;

        sb = new();
        random_sent = 0;
        rst_n              <= 1'b0;
        pix_if.valid       <= 1'b0;
        pix_if.pixel       <= '0;
        pix_if.frame_start <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= lbp_pkg::CFG_IMAGE_WIDTH;
        cfg_data           <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size: a partial first row gives no codes
        gap_pct   = 30;
        stall_pct = 30;
        send_run(8, 1'b1, 1'b0);

        // smallest frame, then a second one that starts by wrapping
        set_size(lbp_pkg::CFG_DATA_W'(3), lbp_pkg::CFG_DATA_W'(3));
        send_grid(grid_hot, 1'b1);
        send_grid(grid_alt, 1'b0);

        // sizes too small for any interior pixel; counters still wrap
        set_size(lbp_pkg::CFG_DATA_W'(0), lbp_pkg::CFG_DATA_W'(4));
        send_run(6, 1'b1, 1'b0);
        set_size(lbp_pkg::CFG_DATA_W'(2), lbp_pkg::CFG_DATA_W'(5));
        send_run(12, 1'b1, 1'b0);
        set_size(lbp_pkg::CFG_DATA_W'(6), lbp_pkg::CFG_DATA_W'(0));
        send_run(8, 1'b1, 1'b0);
        set_size(lbp_pkg::CFG_DATA_W'(5), lbp_pkg::CFG_DATA_W'(2));
        send_run(12, 1'b1, 1'b0);

        // upper data bits beyond the 12-bit width register are dropped
        set_size(16'hF005, lbp_pkg::CFG_DATA_W'(4));
        send_run(20, 1'b1, 1'b0);

        // width shrinks mid-frame while the position sits past the new width
        set_size(lbp_pkg::CFG_DATA_W'(8), lbp_pkg::CFG_DATA_W'(6));
        send_run(8 * 3 + 5, 1'b1, 1'b0);
        wait_idle();
        cfg_write(lbp_pkg::CFG_IMAGE_WIDTH, lbp_pkg::CFG_DATA_W'(4));
        cfg_we <= 1'b0;
        send_run(1 + 4 * 2 + 4 * 3, 1'b0, 1'b0);

        // height shrinks mid-frame below the current row
        wait_idle();
        cfg_write(lbp_pkg::CFG_IMAGE_HEIGHT, lbp_pkg::CFG_DATA_W'(3));
        cfg_we <= 1'b0;
        send_run(4 + 4 * 3, 1'b0, 1'b0);

        // receiver holds off once interior codes flow; the block fills and stalls its input
        gap_pct   = 0;
        stall_pct = 10;
        set_size(lbp_pkg::CFG_DATA_W'(PRESS_W), lbp_pkg::CFG_DATA_W'(3));
        send_run(PRESS_W * 2 + 3, 1'b1, 1'b0);
        hold_off_req = 1'b1;
        send_run(PRESS_W - 3, 1'b0, 1'b0);

        // tallest frame: a few rows only, no frame end
        gap_pct = 20;
        set_size(lbp_pkg::CFG_DATA_W'(3), 16'hFFFF);
        send_run(15, 1'b1, 1'b0);

        // random sizes and contents, some frames wrap in, some are cut short
        while (random_sent < RANDOM_ITEMS)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(3, 12);
            h = $urandom_range(3, 5);
            frames    = $urandom_range(1, 2);
            gap_pct   = $urandom_range(0, 2) * 15;
            stall_pct = $urandom_range(0, 2) * 15;
            set_size(lbp_pkg::CFG_DATA_W'(w), lbp_pkg::CFG_DATA_W'(h));
            for (int unsigned f = 0; f < frames; f++)
            begin
                send_run(w * h, (f == 0) || ($urandom_range(0, 1) == 1), 1'b1);
                random_sent += w * h;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(1, w * h - 1);
                send_run(cut, 1'b1, 1'b1);
                random_sent += cut;
            end
        end

        // closing stretch at full rate
        gap_pct   = 0;
        stall_pct = 0;
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 5);
        set_size(lbp_pkg::CFG_DATA_W'(w), lbp_pkg::CFG_DATA_W'(h));
        send_run(w * h * 2, 1'b1, 1'b0);

        wait_idle();
        $display("covered %0d pixel beats, %0d code beats, %0d frame ends, %0d register writes",
                 sb.pixels_seen, sb.codes_checked, sb.frames_done, cfg_writes);
        $display("sizes from zero up, mid-frame size changes, a %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (sb.mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_if.sv
hw/rtl/lbp_line_mem.sv
hw/rtl/lbp_3x3_feature.sv
tb/sv/lbp_3x3_feature_tb.sv
